FILE: rtl/i2sbcr_pkg.sv
// Shared types, widths and codes for the I2S block capture ring.
`default_nettype none

package i2sbcr_pkg;

   // Default geometry of the capture ring.
   localparam int BLOCK_SAMPLES_DEF = 32;
   localparam int RING_BLOCKS_DEF   = 16;

   // Fixed field widths.
   localparam int WORD_W      = 32;
   localparam int OPC_W       = 2;
   localparam int SAMPLE_W    = 16;
   localparam int SAMPLE_LSB  = 15;
   localparam int COUNT_W     = 32;
   localparam int RSP_TDATA_W = 48;

   // Depth of the result queue in the back end.
   localparam int OQ_DEPTH = 4;
   localparam int OQ_PTR_W = 2;
   localparam int OQ_CNT_W = 3;

   // Request opcodes as they arrive on the input channel.
   localparam logic [OPC_W-1:0] OP_SLOT    = 2'd0;
   localparam logic [OPC_W-1:0] OP_READ    = 2'd1;
   localparam logic [OPC_W-1:0] OP_RESTART = 2'd2;

   // Command kinds passed from the front end to the back end.
   typedef enum logic [1:0] {
      CMD_SLOT,
      CMD_READ,
      CMD_RESTART
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                kind;
      logic [SAMPLE_W-1:0]         sample;
   } cmd_type;

   // Back end sequencer states.
   typedef enum logic {
      ENG_IDLE,
      ENG_STREAM
   } eng_state_type;

   // One result item.
   typedef struct packed {
      logic                        status;
      logic signed [SAMPLE_W-1:0]  sample;
      logic                        last;
      logic [COUNT_W-1:0]          dropped_total;
   } rsp_entry_type;

endpackage : i2sbcr_pkg

`default_nettype wire

FILE: rtl/i2sbcr_front.sv
// Front end: accepts request items, classifies them and queues commands.
`default_nettype none

module i2sbcr_front
   import i2sbcr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [WORD_W-1:0]   req_tdata,
   input  wire logic [OPC_W-1:0]    req_tuser,
   output logic                     cmd_valid,
   input  wire logic                cmd_ready,
   output cmd_type                  cmd
);

   localparam int QDEPTH = 2;

   cmd_type       q_ff [QDEPTH];
   logic          wptr_ff, wptr_in;
   logic          rptr_ff, rptr_in;
   logic [1:0]    cnt_ff, cnt_in;

   logic          accept;
   logic          push;
   logic          pop;
   cmd_type       new_cmd;

   // Classify the request; the unused opcode is accepted and discarded.
   always_comb begin
      push           = 1'b0;
      new_cmd.kind   = CMD_SLOT;
      new_cmd.sample = req_tdata[SAMPLE_LSB +: SAMPLE_W];
      case (req_tuser)
         OP_SLOT: begin
            new_cmd.kind = CMD_SLOT;
            push         = accept;
         end
         OP_READ: begin
            new_cmd.kind = CMD_READ;
            push         = accept;
         end
         OP_RESTART: begin
            new_cmd.kind = CMD_RESTART;
            push         = accept;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   assign req_tready = (cnt_ff != 2'(QDEPTH));
   assign accept     = req_tvalid && req_tready;
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign cmd        = q_ff[rptr_ff];
   assign pop        = cmd_valid && cmd_ready;

   // Queue pointer and fill count.
   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wptr_ff] <= new_cmd;
      end
   end

endmodule : i2sbcr_front

`default_nettype wire

FILE: rtl/i2sbcr_back.sv
// Back end: ring state, sample memory, block read sequencer and result queue.
`default_nettype none

module i2sbcr_back
   import i2sbcr_pkg::*;
#(
   parameter int BLOCK_SAMPLES = BLOCK_SAMPLES_DEF,
   parameter int RING_BLOCKS   = RING_BLOCKS_DEF
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      csr_valid,
   output logic           csr_ready,
   input  wire logic      csr_wdata,
   input  wire logic      cmd_valid,
   output logic           cmd_ready,
   input  wire cmd_type   cmd,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output rsp_entry_type  rsp
);

   localparam int SIDX_W = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
   localparam int SLOT_W = $clog2(2 * BLOCK_SAMPLES);
   localparam int BLK_W  = $clog2(RING_BLOCKS);
   localparam int DEPTH  = RING_BLOCKS * BLOCK_SAMPLES;
   localparam int ADDR_W = $clog2(DEPTH);

   eng_state_type         state_ff, state_in;
   logic                  cap_en_ff, cap_en_in;
   logic [SLOT_W-1:0]     slot_idx_ff, slot_idx_in;
   logic [BLK_W-1:0]      active_ff, active_in;
   logic [BLK_W-1:0]      rd_blk_ff, rd_blk_in;
   logic [COUNT_W-1:0]    produced_ff, produced_in;
   logic [COUNT_W-1:0]    consumed_ff, consumed_in;
   logic [COUNT_W-1:0]    overrun_ff, overrun_in;
   logic [ADDR_W-1:0]     base_ff, base_in;
   logic [SIDX_W-1:0]     scnt_ff, scnt_in;
   logic                  pend_ff, pend_in;
   logic                  pend_last_ff, pend_last_in;
   logic [SAMPLE_W-1:0]   rd_data_ff;

   logic [SAMPLE_W-1:0]   mem [DEPTH];

   rsp_entry_type         oq_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0]   oq_wptr_ff, oq_wptr_in;
   logic [OQ_PTR_W-1:0]   oq_rptr_ff, oq_rptr_in;
   logic [OQ_CNT_W-1:0]   oq_cnt_ff, oq_cnt_in;

   logic                  oq_room;
   logic                  ring_empty;
   logic                  take;
   logic                  start_read;
   logic                  push_empty;
   logic                  issue;
   logic                  issue_last;
   logic                  mem_we;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  push;
   logic                  pop;
   rsp_entry_type         push_entry;
   logic [COUNT_W-1:0]    pending;
   logic                  overrun;
   logic [BLK_W-1:0]      active_next;
   logic [BLK_W-1:0]      read_blk;

   // Shared status terms.
   assign oq_room    = (oq_cnt_ff + OQ_CNT_W'(pend_ff)) < OQ_CNT_W'(OQ_DEPTH);
   assign ring_empty = (produced_ff == consumed_ff);
   assign pending    = produced_ff - consumed_ff;
   assign overrun    = (pending >= COUNT_W'(RING_BLOCKS));
   assign active_next = (active_ff == BLK_W'(RING_BLOCKS - 1)) ? '0 : active_ff + 1'b1;
   assign read_blk   = overrun ? active_next : rd_blk_ff;
   assign csr_ready  = 1'b1;

   // Next state of the read sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ENG_IDLE: begin
            if (start_read) begin
               state_in = ENG_STREAM;
            end
         end
         ENG_STREAM: begin
            if (issue_last) begin
               state_in = ENG_IDLE;
            end
         end
         default: begin
            state_in = ENG_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      cmd_ready  = 1'b0;
      issue      = 1'b0;
      case (state_ff)
         ENG_IDLE: begin
            cmd_ready = (cmd.kind != CMD_READ) || !ring_empty || (oq_room && !pend_ff);
         end
         ENG_STREAM: begin
            issue = oq_room;
         end
         default: begin
            cmd_ready = 1'b0;
         end
      endcase
   end

   assign take       = cmd_valid && cmd_ready;
   assign start_read = take && (cmd.kind == CMD_READ) && !ring_empty;
   assign push_empty = take && (cmd.kind == CMD_READ) && ring_empty;
   assign issue_last = issue && (scnt_ff == SIDX_W'(BLOCK_SAMPLES - 1));
   assign mem_we     = take && (cmd.kind == CMD_SLOT) && cap_en_ff && !slot_idx_ff[0];
   assign wr_addr    = ADDR_W'(active_ff) * ADDR_W'(BLOCK_SAMPLES)
                     + ADDR_W'(slot_idx_ff >> 1);
   assign rd_addr    = base_ff + ADDR_W'(scnt_ff);

   // Ring bookkeeping for each command.
   always_comb begin
      cap_en_in    = cap_en_ff;
      slot_idx_in  = slot_idx_ff;
      active_in    = active_ff;
      rd_blk_in    = rd_blk_ff;
      produced_in  = produced_ff;
      consumed_in  = consumed_ff;
      overrun_in   = overrun_ff;
      base_in      = base_ff;
      scnt_in      = scnt_ff;
      pend_in      = issue;
      pend_last_in = issue_last;

      if (take) begin
         case (cmd.kind)
            CMD_SLOT: begin
               if (cap_en_ff) begin
                  if (slot_idx_ff == SLOT_W'(2 * BLOCK_SAMPLES - 1)) begin
                     slot_idx_in = '0;
                     active_in   = active_next;
                     produced_in = produced_ff + 1'b1;
                  end else begin
                     slot_idx_in = slot_idx_ff + 1'b1;
                  end
               end
            end
            CMD_READ: begin
               if (!ring_empty) begin
                  // Skip the oldest blocks when the whole ring is pending.
                  if (overrun) begin
                     consumed_in = produced_ff - COUNT_W'(RING_BLOCKS - 2);
                     if (overrun_ff != '1) begin
                        overrun_in = overrun_ff + 1'b1;
                     end
                  end else begin
                     consumed_in = consumed_ff + 1'b1;
                  end
                  rd_blk_in = (read_blk == BLK_W'(RING_BLOCKS - 1)) ? '0 : read_blk + 1'b1;
                  base_in   = ADDR_W'(read_blk) * ADDR_W'(BLOCK_SAMPLES);
                  scnt_in   = '0;
               end
            end
            CMD_RESTART: begin
               cap_en_in   = 1'b1;
               slot_idx_in = '0;
               active_in   = '0;
               rd_blk_in   = '0;
               produced_in = '0;
               consumed_in = '0;
               overrun_in  = '0;
            end
            default: begin
               cap_en_in = cap_en_ff;
            end
         endcase
      end

      if (issue) begin
         scnt_in = scnt_ff + 1'b1;
      end

      if (csr_valid) begin
         cap_en_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         cap_en_ff    <= 1'b1;
         slot_idx_ff  <= '0;
         active_ff    <= '0;
         rd_blk_ff    <= '0;
         produced_ff  <= '0;
         consumed_ff  <= '0;
         overrun_ff   <= '0;
         scnt_ff      <= '0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_en_ff    <= cap_en_in;
         slot_idx_ff  <= slot_idx_in;
         active_ff    <= active_in;
         rd_blk_ff    <= rd_blk_in;
         produced_ff  <= produced_in;
         consumed_ff  <= consumed_in;
         overrun_ff   <= overrun_in;
         scnt_ff      <= scnt_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
   end

   // Sample memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= cmd.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Result queue: memory data lands in the cycle after its read is issued.
   always_comb begin
      push = pend_ff || push_empty;
      if (pend_ff) begin
         push_entry.status = 1'b0;
         push_entry.sample = rd_data_ff;
         push_entry.last   = pend_last_ff;
      end else begin
         push_entry.status = 1'b1;
         push_entry.sample = '0;
         push_entry.last   = 1'b0;
      end
      push_entry.dropped_total = overrun_ff;
   end

   assign rsp_valid  = (oq_cnt_ff != '0);
   assign rsp        = oq_ff[oq_rptr_ff];
   assign pop        = rsp_valid && rsp_ready;
   assign oq_wptr_in = push ? oq_wptr_ff + 1'b1 : oq_wptr_ff;
   assign oq_rptr_in = pop ? oq_rptr_ff + 1'b1 : oq_rptr_ff;
   assign oq_cnt_in  = oq_cnt_ff + OQ_CNT_W'(push) - OQ_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wptr_ff <= '0;
         oq_rptr_ff <= '0;
         oq_cnt_ff  <= '0;
      end else begin
         oq_wptr_ff <= oq_wptr_in;
         oq_rptr_ff <= oq_rptr_in;
         oq_cnt_ff  <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         oq_ff[oq_wptr_ff] <= push_entry;
      end
   end

endmodule : i2sbcr_back

`default_nettype wire

FILE: rtl/i2s_block_capture_ring_unit.sv
// Top level of the I2S block capture ring: front end, command queue and back end.
//
//   channel  direction  handshake               payload
//   req      in         req_tvalid/req_tready   tdata slot_word, tuser opcode
//   rsp      out        rsp_tvalid/rsp_tready   tdata sample+dropped_total,
//                                               tuser status, tlast last
//   csr      in         csr_valid/csr_ready     csr_wdata capture_enable
//
// The front end takes one item per cycle into a two-entry command queue while that queue has room.
// A slot word or a restart is handled as the back end takes it; a block read takes a setup step,
// then streams BLOCK_SAMPLES samples, one per cycle while the result queue has room, through
// the single read port of the sample memory, and each result follows in the cycle after its read.
// Reset clears all counters at once; the sample memory has no clearing pass.
// A stalled result side fills the four-entry result queue, then the command
// queue, and only then drops req_tready.
`default_nettype none

module i2s_block_capture_ring_unit
   import i2sbcr_pkg::*;
#(
   parameter int BLOCK_SAMPLES = BLOCK_SAMPLES_DEF,
   parameter int RING_BLOCKS   = RING_BLOCKS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [WORD_W-1:0]        req_tdata,   // [31:0] slot_word
   input  wire logic [OPC_W-1:0]         req_tuser,   // [1:0] opcode
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_TDATA_W-1:0]        rsp_tdata,   // [15:0] sample, [47:16] dropped_total
   output logic                          rsp_tuser,   // [0] status
   output logic                          rsp_tlast,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic                     csr_wdata
);

   logic            cmd_valid;
   logic            cmd_ready;
   cmd_type         cmd;
   rsp_entry_type   rsp;

   i2sbcr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   i2sbcr_back #(
      .BLOCK_SAMPLES (BLOCK_SAMPLES),
      .RING_BLOCKS   (RING_BLOCKS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   // Pack the result item onto the stream.
   assign rsp_tdata = {rsp.dropped_total, rsp.sample};
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last;

`ifndef NO_ASSERTIONS
   // An empty status item never closes a block.
   a_empty_not_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> !rsp_tlast)
      else $error("empty status item carries last");

   // An empty status item carries a zero sample.
   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[SAMPLE_W-1:0] == '0))
      else $error("empty status item carries a sample");

   // Reset empties the result queue.
   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A back end ready while the command queue is empty is not followed by req_tready falling with a result valid.
   a_cmd_handshake : assert property (@(posedge clock) disable iff (reset)
      (cmd_ready && !cmd_valid) |=> !(rsp_tvalid && $fell(req_tready)))
      else $error("command queue stalled while empty");
`endif

endmodule : i2s_block_capture_ring_unit

`default_nettype wire

FILE: sim/tb_i2s_block_capture_ring_unit.sv
// Self-checking testbench for the I2S block capture ring, with a directed table and random episodes.
`default_nettype none

module tb_i2s_block_capture_ring_unit
   import i2sbcr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int BLK          = BLOCK_SAMPLES_DEF;
   localparam int RING         = RING_BLOCKS_DEF;
   localparam int STORE_DEPTH  = BLK * RING;
   localparam int SETTLE       = BLK + 20;
   localparam int LONG_HOLD    = 400;
   localparam int IDLE_LIMIT   = 5000;
   localparam int EPISODES     = 4;
   localparam int MAX_PRINTED  = 40;

   // Opcode 3 has no name in the package; the block ignores it.
   localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

   localparam rsp_entry_type NO_BLOCK = '{status: 1'b1, sample: '0, last: 1'b0,
                                          dropped_total: '0};

   typedef struct {
      logic [OPC_W-1:0]  op;
      logic [WORD_W-1:0] word;
      int                reps;
      bit                typed;
      rsp_entry_type     want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [WORD_W-1:0]      req_tdata = '0;
   logic [OPC_W-1:0]       req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic                   csr_wdata = 1'b0;

   i2s_block_capture_ring_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [31:0] slot_word
      .req_tuser  (req_tuser),   // [1:0] opcode
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [15:0] sample, [47:16] dropped_total
      .rsp_tuser  (rsp_tuser),   // [0] status
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   // Mirror of the capture ring state.
   logic [SAMPLE_W-1:0] ring_mem [STORE_DEPTH];
   int unsigned         slot_pos;
   int unsigned         fill_block;
   logic [COUNT_W-1:0]  blocks_done;
   logic [COUNT_W-1:0]  blocks_read;
   logic [COUNT_W-1:0]  overruns;
   bit                  capture_on;

   rsp_entry_type pending_rsps[$];
   int            errors = 0;
   int            hold_ticket = 0;
   int            hold_served = 0;
   bit            steady_flow = 1'b0;

   // Clock generation.
   initial begin
      forever #5 clock = ~clock;
   end

   // Gap length: mostly none, sometimes short, now and then long.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void clear_ring_counters();
      slot_pos    = 0;
      fill_block  = 0;
      blocks_done = '0;
      blocks_read = '0;
      overruns    = '0;
   endfunction

   // Advance the mirrored state by one accepted item and queue the results it yields.
   function automatic void capture_ring_step(logic [OPC_W-1:0] op, logic [WORD_W-1:0] word,
                                             bit queue_rsps);
      rsp_entry_type r;
      int unsigned   blk;
      case (op)
         OP_SLOT: begin
            if (capture_on) begin
               if (slot_pos % 2 == 0)
                  ring_mem[fill_block * BLK + slot_pos / 2] = word[SAMPLE_LSB +: SAMPLE_W];
               slot_pos++;
               if (slot_pos == 2 * BLK) begin
                  slot_pos    = 0;
                  fill_block  = (fill_block + 1) % RING;
                  blocks_done = blocks_done + 1;
               end
            end
         end
         OP_READ: begin
            if (blocks_done == blocks_read) begin
               r = NO_BLOCK;
               r.dropped_total = overruns;
               if (queue_rsps) pending_rsps.push_back(r);
            end else begin
               // A full ring of pending blocks skips the oldest ones.
               if (blocks_done - blocks_read >= RING) begin
                  blocks_read = blocks_done - (RING - 1);
                  if (overruns != '1) overruns = overruns + 1;
               end
               blk = blocks_read % RING;
               blocks_read = blocks_read + 1;
               for (int i = 0; i < BLK; i++) begin
                  r.status        = 1'b0;
                  r.sample        = ring_mem[blk * BLK + i];
                  r.last          = (i == BLK - 1);
                  r.dropped_total = overruns;
                  if (queue_rsps) pending_rsps.push_back(r);
               end
            end
         end
         OP_RESTART: begin
            clear_ring_counters();
            capture_on = 1'b1;
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                  input logic [COUNT_W-1:0] want);
      errors++;
      if (errors <= MAX_PRINTED)
         $display("tb: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
   endtask

   // Offer one item after a random gap and wait for the handshake.
   task automatic send_item(input logic [OPC_W-1:0] op, input logic [WORD_W-1:0] word,
                            input bit typed, input rsp_entry_type want);
      int g;
      g = steady_flow ? 0 : gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      capture_ring_step(op, word, !typed);
      if (typed) pending_rsps.push_back(want);
   endtask

   // Stop offering, wait for every expected result, then let the block settle.
   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_capture_enable(input bit value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      capture_on = value;
      csr_valid <= 1'b0;
   endtask

   // Result side: random stalls, plus one long hold on request.
   always @(posedge clock) begin : rsp_ready_drive
      int stall_left;
      int g;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else if (hold_ticket != hold_served) begin
         hold_served = hold_ticket;
         stall_left  = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         g = steady_flow ? 0 : gap_len();
         if (g > 0) begin
            stall_left = g - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin : rsp_compare
      rsp_entry_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsps.size() == 0) begin
            report_mismatch("unexpected result, sample",
                            COUNT_W'(rsp_tdata[SAMPLE_W-1:0]), '0);
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_tuser !== want.status)
               report_mismatch("status", COUNT_W'(rsp_tuser), COUNT_W'(want.status));
            if (rsp_tdata[15:0] !== want.sample)
               report_mismatch("sample", COUNT_W'(rsp_tdata[SAMPLE_W-1:0]),
                               COUNT_W'($unsigned(want.sample)));
            if (rsp_tlast !== want.last)
               report_mismatch("last", COUNT_W'(rsp_tlast), COUNT_W'(want.last));
            if (rsp_tdata[47:16] !== want.dropped_total)
               report_mismatch("dropped_total", rsp_tdata[47:16], want.dropped_total);
         end
      end
   end

   // Watchdog on cycles with no handshake on any channel.
   always @(posedge clock) begin : idle_watchdog
      int idle_cycles;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Directed items: extremes of the sample field, every opcode, empty reads and restart.
   stim_row_type directed_rows [15] = '{
      '{OP_READ,    32'h0000_0000,  1, 1'b1, NO_BLOCK},  // empty ring after reset
      '{OP_UNUSED,  32'hFFFF_FFFF,  1, 1'b0, NO_BLOCK},
      '{OP_SLOT,    32'h3FFF_8000,  1, 1'b0, NO_BLOCK},  // largest positive sample
      '{OP_SLOT,    32'hFFFF_FFFF,  1, 1'b0, NO_BLOCK},  // right slot, not stored
      '{OP_SLOT,    32'h4000_0000,  1, 1'b0, NO_BLOCK},  // most negative sample
      '{OP_SLOT,    32'h0000_0000,  1, 1'b0, NO_BLOCK},
      '{OP_SLOT,    32'h8000_7FFF,  1, 1'b0, NO_BLOCK},  // only ignored bits set
      '{OP_SLOT,    32'h0000_0000,  1, 1'b0, NO_BLOCK},
      '{OP_SLOT,    32'hFFFF_FFFF, 58, 1'b0, NO_BLOCK},  // completes the first block
      '{OP_READ,    32'hFFFF_FFFF,  1, 1'b0, NO_BLOCK},
      '{OP_READ,    32'h0000_0000,  1, 1'b1, NO_BLOCK},  // block already read
      '{OP_SLOT,    32'hAAAA_5555, 11, 1'b0, NO_BLOCK},  // partial block
      '{OP_RESTART, 32'hFFFF_FFFF,  1, 1'b0, NO_BLOCK},  // drops the partial block
      '{OP_READ,    32'h0000_0000,  1, 1'b1, NO_BLOCK},
      '{OP_UNUSED,  32'h0000_0000,  1, 1'b0, NO_BLOCK}
   };

   // Main sequence.
   initial begin : stimulus
      int  nblk;
      int  nslot;
      int  nread;
      int  pick;

      clear_ring_counters();
      capture_on = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_capture_enable(1'b1);

      foreach (directed_rows[r]) begin
         for (int k = 0; k < directed_rows[r].reps; k++)
            send_item(directed_rows[r].op, directed_rows[r].word,
                      directed_rows[r].typed, directed_rows[r].want);
      end

      // Random episodes; the second sends at least a block's worth of items and reads under a long hold.
      for (int ep = 0; ep < EPISODES; ep++) begin
         drain_and_settle();
         write_capture_enable((ep == 2) ? 1'b0 : 1'b1);
         steady_flow = (ep == 3);
         nblk  = (ep == 1) ? 1 : 0;
         nslot = nblk * 2 * BLK + $urandom_range(0, 20);
         for (int k = 0; k < nslot; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
               send_item(OP_READ, $urandom(), 1'b0, NO_BLOCK);
            else if (pick < 14)
               send_item(OP_UNUSED, $urandom(), 1'b0, NO_BLOCK);
            else if (pick < 17)
               send_item(OP_RESTART, $urandom(), 1'b0, NO_BLOCK);
            else
               send_item(OP_SLOT, $urandom(), 1'b0, NO_BLOCK);
         end
         // Hold the result side off while reads keep arriving, so the input stalls.
         if (ep == 1) hold_ticket++;
         nread = (ep == 1) ? 8 : $urandom_range(1, 4);
         for (int k = 0; k < nread; k++)
            send_item(OP_READ, $urandom(), 1'b0, NO_BLOCK);
      end

      drain_and_settle();
      if (errors == 0 && pending_rsps.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
